// ===== hdl/mslr_pkg.sv =====
// Shared types and constants of the multi-stream Lehmer generator.
// No dependencies; imported by every module of the block.
package mslr_pkg;

    localparam int NUM_STREAMS_DEF = 64;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam int S_DATA_W = 104;
    localparam int M_DATA_W = 64;

    localparam logic [14:0] LCG_MULT = 15'd16807;
    localparam logic [30:0] LCG_MOD  = 31'h7FFF_FFFF;
    localparam logic [63:0] LCG_MASK = 64'd123459876;

    localparam logic [1:0] CMD_SEED  = 2'd0;
    localparam logic [1:0] CMD_DRAW  = 2'd1;
    localparam logic [1:0] CMD_RANGE = 2'd2;
    localparam logic [1:0] CMD_SKEW  = 2'd3;

    typedef enum logic [2:0] {
        KIND_NOP   = 3'd0,
        KIND_SEED  = 3'd1,
        KIND_DRAW  = 3'd2,
        KIND_RANGE = 3'd3,
        KIND_SKEW  = 3'd4,
        KIND_ERROR = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [5:0]  idx;
        logic [31:0] lo;
        logic [32:0] span;
        logic [30:0] bound;
    } op_entry_t;

endpackage

// ===== hdl/mslr_front.sv =====
// Front end: unpacks an input request and classifies it for the engine.
// Depends on mslr_pkg.
module mslr_front
    import mslr_pkg::*;
#(
    parameter int NUM_STREAMS = NUM_STREAMS_DEF
) (
    input  logic                s_tvalid,
    output logic                s_tready,
    // command[1:0], stream[7:2], range_low[39:8], range_high[71:40],
    // skew_bound[102:72], zero[103]
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                push_valid,
    output op_entry_t           push_entry,
    input  logic                push_ready
);

    logic [1:0]  cmd;
    logic [5:0]  stream;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [32:0] lo_b;
    logic [32:0] hi_b;
    logic        in_range;
    logic        bad_range;

    assign cmd    = s_tdata[1:0];
    assign stream = s_tdata[7:2];
    assign lo     = s_tdata[39:8];
    assign hi     = s_tdata[71:40];

    // bias the signed bounds so that plain unsigned compare and subtract apply
    assign lo_b      = {1'b0, lo ^ 32'h8000_0000};
    assign hi_b      = {1'b0, hi ^ 32'h8000_0000};
    assign bad_range = hi_b < lo_b;
    assign in_range  = 32'(stream) < 32'(NUM_STREAMS);

    always_comb begin
        push_entry.idx   = stream;
        push_entry.lo    = lo;
        push_entry.span  = hi_b - lo_b + 33'd1;
        push_entry.bound = s_tdata[102:72];
        if (!in_range) begin
            push_entry.kind = KIND_NOP;
        end else begin
            unique case (cmd)
                CMD_SEED:  push_entry.kind = KIND_SEED;
                CMD_DRAW:  push_entry.kind = KIND_DRAW;
                CMD_RANGE: push_entry.kind = bad_range ? KIND_ERROR : KIND_RANGE;
                CMD_SKEW:  push_entry.kind = bad_range ? KIND_ERROR : KIND_SKEW;
                default:   push_entry.kind = KIND_NOP;
            endcase
        end
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

// ===== hdl/mslr_queue.sv =====
// Short request queue between the front end and the engine.
// Depends on mslr_pkg.
module mslr_queue
    import mslr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    output logic      push_ready,
    input  op_entry_t push_entry,
    output logic      pop_valid,
    output op_entry_t pop_entry,
    input  logic      pop
);

    op_entry_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                push;
    logic                take;

    assign push_ready = count_reg < QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign take       = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (take) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !take) begin
            count_next = count_reg + 1'b1;
        end else if (take && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hdl/mslr_back.sv =====
// Engine: seed store, modular draw, scaling and remainder loop, result register.
// Depends on mslr_pkg; fed by mslr_queue.
module mslr_back
    import mslr_pkg::*;
#(
    parameter int NUM_STREAMS = NUM_STREAMS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [63:0]         root_seed,
    input  logic                q_valid,
    input  op_entry_t           q_entry,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    // fraction[30:0], value[62:31], range_error[63]
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int DEPTH = (NUM_STREAMS < 64) ? NUM_STREAMS : 64;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [11:0] {
        S_IDLE   = 12'h001,
        S_READ   = 12'h002,
        S_FOLD   = 12'h004,
        S_MUL    = 12'h008,
        S_RED    = 12'h010,
        S_SMUL   = 12'h020,
        S_SQ1    = 12'h040,
        S_SQ2    = 12'h080,
        S_POST   = 12'h100,
        S_DIV    = 12'h200,
        S_DIVEND = 12'h400,
        S_FINISH = 12'h800
    } state_t;

    state_t        state_reg, state_next;
    op_entry_t     ent_reg, ent_next;
    logic          second_reg, second_next;
    logic          out_valid_reg, out_valid_next;
    logic [63:0]   out_data_reg, out_data_next;

    logic [32:0]   acc_reg, acc_next;
    logic [30:0]   r_reg, r_next;
    logic [45:0]   prod_reg, prod_next;
    logic [30:0]   y_reg, y_next;
    logic [63:0]   sprod_reg, sprod_next;
    logic [32:0]   q1_reg, q1_next;
    logic [33:0]   r1_reg, r1_next;
    logic [31:0]   scaled_reg, scaled_next;
    logic [31:0]   a_reg, a_next;
    logic [31:0]   x_reg, x_next;
    logic [32:0]   rem_reg, rem_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic [30:0]   res_frac_reg, res_frac_next;
    logic [31:0]   res_val_reg, res_val_next;
    logic          res_err_reg, res_err_next;

    logic [63:0]   seed_mem [DEPTH];
    logic [DEPTH-1:0] seed_vld_reg;
    logic [63:0]   rd_data_reg;
    logic          rd_vld_reg;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    logic [63:0]   mem_wdata;

    logic [63:0]   seed;
    logic [63:0]   s_x;
    logic [127:0]  rot_wide;
    logic [31:0]   fold2;
    logic [31:0]   red_t;
    logic [30:0]   red_y;
    logic [32:0]   mult;
    logic [2:0]    q2;
    logic [31:0]   r2;
    logic          r2_ge;
    logic [31:0]   b_val;
    logic [32:0]   div_sh;

    assign mem_addr = (state_reg == S_IDLE) ? q_entry.idx[AW-1:0] : ent_reg.idx[AW-1:0];
    assign rot_wide = {root_seed, root_seed} << q_entry.idx;

    assign seed  = rd_vld_reg ? rd_data_reg : '0;
    assign s_x   = seed ^ LCG_MASK;
    // 2^31 is 1 modulo 2^31-1: fold the word in 31-bit slices
    assign fold2 = 32'(acc_reg[30:0]) + 32'(acc_reg[32:31]);
    assign red_t = 32'(prod_reg[30:0]) + 32'(prod_reg[45:31]);
    assign red_y = (red_t >= 32'(LCG_MOD)) ? 31'(red_t - 32'(LCG_MOD)) : red_t[30:0];
    assign mult  = (ent_reg.kind == KIND_SKEW && !second_reg) ?
                   {1'b0, 32'(ent_reg.bound) + 32'd1} : ent_reg.span;
    assign q2    = r1_reg[33:31];
    assign r2    = 32'(r1_reg[30:0]) + 32'(q2);
    assign r2_ge = r2 >= 32'(LCG_MOD);
    assign b_val = ent_reg.lo + scaled_reg;
    assign div_sh = {rem_reg[31:0], x_reg[31]};

    always_comb begin
        state_next     = state_reg;
        ent_next       = ent_reg;
        second_next    = second_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        acc_next       = acc_reg;
        r_next         = r_reg;
        prod_next      = prod_reg;
        y_next         = y_reg;
        sprod_next     = sprod_reg;
        q1_next        = q1_reg;
        r1_next        = r1_reg;
        scaled_next    = scaled_reg;
        a_next         = a_reg;
        x_next         = x_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        res_frac_next  = res_frac_reg;
        res_val_next   = res_val_reg;
        res_err_next   = res_err_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_wdata      = '0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop         = 1'b1;
                    mem_re        = 1'b1;
                    ent_next      = q_entry;
                    second_next   = 1'b0;
                    res_frac_next = '0;
                    res_val_next  = '0;
                    res_err_next  = 1'b0;
                    unique case (q_entry.kind)
                        KIND_SEED: begin
                            mem_we     = 1'b1;
                            mem_wdata  = rot_wide[127:64];
                            state_next = S_FINISH;
                        end
                        KIND_DRAW, KIND_RANGE, KIND_SKEW: begin
                            state_next = S_READ;
                        end
                        KIND_ERROR: begin
                            res_err_next = 1'b1;
                            state_next   = S_FINISH;
                        end
                        default: begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_READ: begin
                acc_next   = 33'(s_x[30:0]) + 33'(s_x[61:31]) + 33'(s_x[63:62]);
                state_next = S_FOLD;
            end
            S_FOLD: begin
                r_next     = (fold2 >= 32'(LCG_MOD)) ? 31'(fold2 - 32'(LCG_MOD)) : fold2[30:0];
                state_next = S_MUL;
            end
            S_MUL: begin
                prod_next  = 46'(r_reg) * 46'(LCG_MULT);
                state_next = S_RED;
            end
            S_RED: begin
                y_next     = red_y;
                mem_we     = 1'b1;
                mem_wdata  = 64'(red_y) ^ LCG_MASK;
                if (ent_reg.kind == KIND_DRAW) begin
                    res_frac_next = red_y;
                    state_next    = S_FINISH;
                end else begin
                    state_next = S_SMUL;
                end
            end
            S_SMUL: begin
                sprod_next = 64'(y_reg) * 64'(mult);
                state_next = S_SQ1;
            end
            S_SQ1: begin
                // floor of a product divided by 2^31-1: fold the quotient twice
                q1_next    = sprod_reg[63:31];
                r1_next    = 34'(sprod_reg[63:31]) + 34'(sprod_reg[30:0]);
                state_next = S_SQ2;
            end
            S_SQ2: begin
                scaled_next = 32'(q1_reg + 33'(q2) + 33'(r2_ge));
                state_next  = S_POST;
            end
            S_POST: begin
                if (ent_reg.kind == KIND_RANGE) begin
                    res_frac_next = y_reg;
                    res_val_next  = b_val;
                    state_next    = S_FINISH;
                end else if (!second_reg) begin
                    // second draw starts from the stored seed, which unmasks to y
                    a_next      = scaled_reg;
                    second_next = 1'b1;
                    r_next      = y_reg;
                    state_next  = S_MUL;
                end else begin
                    x_next     = a_reg | b_val;
                    rem_next   = '0;
                    cnt_next   = 5'd31;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                rem_next = (div_sh >= ent_reg.span) ? div_sh - ent_reg.span : div_sh;
                x_next   = x_reg << 1;
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    state_next = S_DIVEND;
                end
            end
            S_DIVEND: begin
                res_frac_next = y_reg;
                res_val_next  = ent_reg.lo + rem_reg[31:0];
                state_next    = S_FINISH;
            end
            S_FINISH: begin
                // hold until the result register is free
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {res_err_reg, res_val_reg, res_frac_reg};
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            seed_vld_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            second_reg    <= second_next;
            out_valid_reg <= out_valid_next;
            if (mem_we) begin
                seed_vld_reg[mem_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg      <= ent_next;
        out_data_reg <= out_data_next;
        acc_reg      <= acc_next;
        r_reg        <= r_next;
        prod_reg     <= prod_next;
        y_reg        <= y_next;
        sprod_reg    <= sprod_next;
        q1_reg       <= q1_next;
        r1_reg       <= r1_next;
        scaled_reg   <= scaled_next;
        a_reg        <= a_next;
        x_reg        <= x_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        res_frac_reg <= res_frac_next;
        res_val_reg  <= res_val_next;
        res_err_reg  <= res_err_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            seed_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= seed_mem[mem_addr];
            rd_vld_reg  <= seed_vld_reg[mem_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_fold_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MUL) |-> (r_reg < LCG_MOD))
        else $error("folded seed not reduced below the modulus");

    a_draw_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RED) |-> (mem_we && ((mem_wdata ^ LCG_MASK) < 64'(LCG_MOD))))
        else $error("stored draw not reduced below the modulus");

    a_rem_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (rem_reg < ent_reg.span))
        else $error("remainder escaped the span");

    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (q_valid && state_reg == S_IDLE))
        else $error("queue popped while empty or engine busy");

endmodule

// ===== hdl/multi_stream_lehmer_rng_core.sv =====
// Top level of the multi-stream Lehmer generator.
// Depends on mslr_pkg, mslr_front, mslr_queue and mslr_back.
//
// Keeps a 64-bit seed for each stream (cleared at reset) and answers every
// request with one result. Requests enter a four-entry queue at up to one a
// cycle while the queue has room; a single engine then works one request at
// a time. A seed load, an out-of-range stream or a range error goes straight
// to the result; a unit draw runs the modular draw once, a range draw adds
// the scaling, and a skewed draw runs draw and scaling twice and then the
// 32-step remainder loop. The result register lets the engine finish its
// next request while a result waits. The master seed may be written only
// while idle.
module multi_stream_lehmer_rng_core
    import mslr_pkg::*;
#(
    parameter int NUM_STREAMS = NUM_STREAMS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [63:0]         cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // command[1:0], stream[7:2], range_low[39:8], range_high[71:40],
    // skew_bound[102:72], zero[103]
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // fraction[30:0], value[62:31], range_error[63]
    output logic [M_DATA_W-1:0] m_tdata
);

    logic [63:0] root_seed_reg;
    logic        push_valid;
    logic        push_ready;
    op_entry_t   push_entry;
    logic        pop_valid;
    op_entry_t   pop_entry;
    logic        pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_seed_reg <= '0;
        end else if (cfg_we) begin
            root_seed_reg <= cfg_wdata;
        end
    end

    mslr_front #(
        .NUM_STREAMS (NUM_STREAMS)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready)
    );

    mslr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop        (pop)
    );

    mslr_back #(
        .NUM_STREAMS (NUM_STREAMS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .root_seed   (root_seed_reg),
        .q_valid     (pop_valid),
        .q_entry     (pop_entry),
        .q_pop       (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for multi_stream_lehmer_rng_core: random streamed requests,
// stalls on both sides and a bit-exact predictor of every result.
// Depends on mslr_pkg and the RTL of the block only.
module tb_top;
    import mslr_pkg::*;

    localparam int          LIMIT_CYCLES = 400000;
    localparam int          SETTLE       = 60;
    localparam int          REPORT_CAP   = 100;
    localparam logic [63:0] MOD64        = 64'(LCG_MOD);
    localparam logic [63:0] MULT64       = 64'(LCG_MULT);

    typedef struct {
        logic [1:0]         cmd;
        logic [5:0]         stream;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic [30:0]        bound;
    } gen_req_t;

    typedef struct packed {
        logic              range_error;
        logic [31:0]       value;
        logic [30:0]       fraction;
    } gen_result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_we = 1'b0;
    logic [63:0]         cfg_wdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // command, stream, range_low, range_high, skew_bound, zero pad
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // fraction, value, range_error
    logic [M_DATA_W-1:0] m_tdata;

    // predictor state
    logic [63:0] seed_store [64];
    logic [63:0] master_copy = '0;

    gen_req_t    req_backlog[$];
    gen_result_t predicted_results[$];
    gen_req_t    cur_req;

    int n_accepted = 0, n_results = 0, n_errors = 0, n_reports = 0, n_settings = 1;
    int n_seed = 0, n_draw = 0, n_range = 0, n_skew = 0, n_range_err = 0;
    int cycles = 0;

    multi_stream_lehmer_rng_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [63:0] advance_stream(logic [5:0] idx);
        logic [63:0] folded;
        logic [63:0] y;
        folded = seed_store[idx] ^ LCG_MASK;
        y = ((folded % MOD64) * MULT64) % MOD64;
        seed_store[idx] = y ^ LCG_MASK;
        return y;
    endfunction

    // y < 2^31 and span <= 2^32, so the product fits in 64 bits
    function automatic logic [63:0] scale_draw(logic [63:0] y, logic [63:0] span);
        return (y * span) / MOD64;
    endfunction

    function automatic gen_result_t predict_result(gen_req_t r);
        gen_result_t res;
        logic [63:0] span;
        logic [63:0] y;
        logic [31:0] a32;
        logic [31:0] b32;
        res = '0;
        case (r.cmd)
            CMD_SEED: begin
                // a shift by 64 yields zero, so stream 0 takes the master seed as is
                seed_store[r.stream] = (master_copy << r.stream) |
                                       (master_copy >> (64 - int'(r.stream)));
                n_seed++;
            end
            CMD_DRAW: begin
                y = advance_stream(r.stream);
                res.fraction = y[30:0];
                n_draw++;
            end
            default: begin
                if (r.hi < r.lo) begin
                    res.range_error = 1'b1;
                    n_range_err++;
                end else begin
                    span = 64'(longint'(r.hi) - longint'(r.lo)) + 64'd1;
                    if (r.cmd == CMD_RANGE) begin
                        y = advance_stream(r.stream);
                        res.fraction = y[30:0];
                        res.value = 32'(r.lo) + 32'(scale_draw(y, span));
                        n_range++;
                    end else begin
                        a32 = 32'(scale_draw(advance_stream(r.stream), 64'(r.bound) + 64'd1));
                        y = advance_stream(r.stream);
                        res.fraction = y[30:0];
                        b32 = 32'(r.lo) + 32'(scale_draw(y, span));
                        res.value = 32'(r.lo) + 32'(64'(a32 | b32) % span);
                        n_skew++;
                    end
                end
            end
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic gen_req_t make_req(logic [1:0] cmd, logic [5:0] stream,
                                          logic [31:0] lo, logic [31:0] hi,
                                          logic [30:0] bound);
        gen_req_t r;
        r.cmd = cmd;
        r.stream = stream;
        r.lo = lo;
        r.hi = hi;
        r.bound = bound;
        return r;
    endfunction

    function automatic gen_req_t random_req();
        gen_req_t r;
        int sel;
        logic signed [31:0] x, z;
        sel = $urandom_range(0, 99);
        r.cmd = (sel < 15) ? CMD_SEED : (sel < 45) ? CMD_DRAW :
                (sel < 75) ? CMD_RANGE : CMD_SKEW;
        // mostly a handful of streams so each one runs through long sequences
        r.stream = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(0, 7));
        x = $urandom;
        z = $urandom;
        case ($urandom_range(0, 9))
            0: begin
                r.lo = x;
                r.hi = z;
            end
            1, 2, 3: begin
                r.lo = (x < z) ? x : z;
                r.hi = (x < z) ? z : x;
            end
            4, 5, 6: begin
                if (x > 32'sh7FFF_F000) x = x - 32'sd8192;
                r.lo = x;
                r.hi = x + 32'($urandom_range(0, 1000));
            end
            7: begin
                r.lo = 32'sh8000_0000;
                r.hi = 32'sh7FFF_FFFF;
            end
            8: begin
                // force high below low
                if (x == z) z = x - 32'sd1;
                r.lo = (x > z) ? x : z;
                r.hi = (x > z) ? z : x;
            end
            default: begin
                r.lo = x;
                r.hi = x;
            end
        endcase
        case ($urandom_range(0, 5))
            0:       r.bound = '0;
            1:       r.bound = 31'h7FFF_FFFF;
            2:       r.bound = 31'($urandom_range(0, 255));
            default: r.bound = 31'($urandom);
        endcase
        return r;
    endfunction

    task automatic drain_block();
        while (req_backlog.size() != 0 || s_tvalid || predicted_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_master(logic [63:0] v);
        drain_block();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        master_copy = v;
        n_settings++;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        logic [63:0] masters [5];
        masters[0] = {$urandom, $urandom};
        masters[1] = 64'h1;
        masters[2] = 64'h8000_0000_0000_0000;
        masters[3] = {$urandom, $urandom};
        masters[4] = 64'h0;
        for (int i = 0; i < 64; i++) seed_store[i] = '0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset master seed: unseeded stream, seed load with zero master
        req_backlog.push_back(make_req(CMD_DRAW, 6'd5, 0, 0, 0));
        req_backlog.push_back(make_req(CMD_SEED, 6'd5, 0, 0, 0));
        req_backlog.push_back(make_req(CMD_DRAW, 6'd5, 0, 0, 0));
        req_backlog.push_back(make_req(CMD_RANGE, 6'd7, 0, 9, 0));
        req_backlog.push_back(make_req(CMD_SKEW, 6'd7, 0, 9, 31'd3));

        write_master(64'hFFFF_FFFF_FFFF_FFFF);
        req_backlog.push_back(make_req(CMD_SEED, 6'd0, 0, 0, 0));
        req_backlog.push_back(make_req(CMD_SEED, 6'd1, 0, 0, 0));
        req_backlog.push_back(make_req(CMD_SEED, 6'd63, 0, 0, 0));
        req_backlog.push_back(make_req(CMD_DRAW, 6'd0, 0, 0, 0));
        req_backlog.push_back(make_req(CMD_DRAW, 6'd63, 0, 0, 0));
        req_backlog.push_back(make_req(CMD_RANGE, 6'd1, 0, 0, 0));
        req_backlog.push_back(make_req(CMD_RANGE, 6'd1, 32'h8000_0000, 32'h7FFF_FFFF, 0));
        req_backlog.push_back(make_req(CMD_RANGE, 6'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
        req_backlog.push_back(make_req(CMD_RANGE, 6'd1, 32'd5, -32'sd5, 0));
        req_backlog.push_back(make_req(CMD_SKEW, 6'd0, -32'sd100, 32'd100, 31'd0));
        req_backlog.push_back(make_req(CMD_SKEW, 6'd63, 32'h8000_0000, 32'h7FFF_FFFF,
                                       31'h7FFF_FFFF));
        req_backlog.push_back(make_req(CMD_SKEW, 6'd63, 32'h7FFF_FFFF, 32'h8000_0000, 0));
        req_backlog.push_back(make_req(CMD_SKEW, 6'd1, 32'h8000_0000, 32'h8000_0000,
                                       31'h7FFF_FFFE));
        req_backlog.push_back(make_req(CMD_RANGE, 6'd2, 32'h8000_0000, 32'hFFFF_FFFF, 0));
        req_backlog.push_back(make_req(CMD_SEED, 6'd32, 0, 0, 0));
        req_backlog.push_back(make_req(CMD_DRAW, 6'd32, 0, 0, 0));
        req_backlog.push_back(make_req(CMD_SKEW, 6'd32, 0, 32'h0000_FFFF, 31'd12345));

        foreach (masters[p]) begin
            write_master(masters[p]);
            repeat (190) req_backlog.push_back(random_req());
        end

        drain_block();
        $display("Covered %0d requests under %0d master seed settings:", n_accepted,
                 n_settings);
        $display("  %0d seed loads, %0d unit, %0d range and %0d skewed draws, %0d range errors",
                 n_seed, n_draw, n_range, n_skew, n_range_err);
        if (n_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // ---------------------------------------------------------------- driver

    int burst_left = 1;
    int gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predicted_results.push_back(predict_result(cur_req));
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (req_backlog.size() != 0) begin
                    cur_req = req_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {1'b0, cur_req.bound, cur_req.hi, cur_req.lo,
                                cur_req.stream, cur_req.cmd};
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    int hold_left = 0;
    int next_hold = 250;
    int stall_mode = 0;
    int stall_left = 0;
    int pat_ctr = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            // hold off long enough for the queue to fill and back-pressure the input
            if (n_accepted >= next_hold && next_hold < 1000) begin
                hold_left = 300;
                next_hold += 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (stall_left == 0) begin
                    stall_mode = $urandom_range(0, 2);
                    stall_left = $urandom_range(20, 150);
                end else begin
                    stall_left--;
                end
                pat_ctr = (pat_ctr + 1) % 5;
                case (stall_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 9) < 6);
                    default: m_tready <= (pat_ctr >= 2);
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge aclk) begin
        gen_result_t got;
        gen_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            n_results++;
            if (predicted_results.size() == 0) begin
                n_errors++;
                if (n_reports++ < REPORT_CAP)
                    $display("%0t: result with nothing outstanding: fraction %h value %h err %b",
                             $realtime, got.fraction, got.value, got.range_error);
            end else begin
                want = predicted_results.pop_front();
                if (got.fraction !== want.fraction) begin
                    n_errors++;
                    if (n_reports++ < REPORT_CAP)
                        $display("%0t: fraction mismatch, expected %h, actual %h",
                                 $realtime, want.fraction, got.fraction);
                end
                if (got.value !== want.value) begin
                    n_errors++;
                    if (n_reports++ < REPORT_CAP)
                        $display("%0t: value mismatch, expected %h, actual %h",
                                 $realtime, want.value, got.value);
                end
                if (got.range_error !== want.range_error) begin
                    n_errors++;
                    if (n_reports++ < REPORT_CAP)
                        $display("%0t: range_error mismatch, expected %b, actual %b",
                                 $realtime, want.range_error, got.range_error);
                end
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycles, predicted_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule

// ===== files.f =====
hdl/mslr_pkg.sv
hdl/mslr_front.sv
hdl/mslr_queue.sv
hdl/mslr_back.sv
hdl/multi_stream_lehmer_rng_core.sv
tb/tb_top.sv
